[rtl/nca_pkg.sv]
// Shared types and codes for the nearest cell assignment block.
// No dependencies; imported by the core and its checker.
`timescale 1ns / 1ps

package nca_pkg;

   localparam int NCA_TABLE_CELLS = 64;

   localparam int COORD_W = 12;
   localparam int DIST_W  = 2 * COORD_W + 1;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_LOAD  = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [7:0]         cell_row;
      logic [7:0]         cell_col;
      logic [COORD_W-1:0] cell_x;
      logic [COORD_W-1:0] cell_y;
      logic [COORD_W-1:0] box_x;
      logic [COORD_W-1:0] box_y;
      logic [9:0]         box_id;
   } nca_req_type;

   typedef struct packed {
      logic       matched;
      logic [7:0] match_row;
      logic [7:0] match_col;
      logic [9:0] match_box_id;
   } nca_rsp_type;

   // one table entry, 40 bits
   typedef struct packed {
      logic [7:0]         row;
      logic [7:0]         col;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } nca_cell_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } nca_state_type;

endpackage

[rtl/nearest_cell_assignment_core.sv]
// Nearest cell assignment: cell table memory, scan pipeline and result register.
// Depends on nca_pkg.
`timescale 1ns / 1ps

// Keeps up to TABLE_CELLS grid cells (row, column, centroid x/y) in a
// synchronous RAM with one write and one read port and answers
// nearest-centroid queries. A clear word empties the table and a load word
// appends one cell (ignored when the table is full); neither closes the
// input. A query word walks the stored cells in load order, one RAM read per
// cycle, through a four-stage pipe (read, absolute difference, squaring,
// compare) and returns the row and column of the cell with the smallest
// exact squared distance; on a tie the earlier cell wins. A query keeps
// req_stall high through the scan, drain and finish states and while its
// result waits for the previous result to leave the output register; an
// empty table skips the scan and answers matched = 0. The result sits in
// an output register, so the next word is taken while a result still waits
// on rsp_stall. Loads and scan reads never overlap: the table is only
// written while no scan runs.
module nearest_cell_assignment_core #(
   parameter int TABLE_CELLS = nca_pkg::NCA_TABLE_CELLS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  nca_pkg::nca_req_type req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output nca_pkg::nca_rsp_type rsp_word
);
   import nca_pkg::*;

   localparam int IDX_W = (TABLE_CELLS > 1) ? $clog2(TABLE_CELLS) : 1;
   localparam int CNT_W = $clog2(TABLE_CELLS + 1);

   // cell table
   nca_cell_type mem [TABLE_CELLS];

   nca_state_type state_ff, state_in;

   logic [CNT_W-1:0] count_ff;
   logic [IDX_W-1:0] idx_ff;

   // latched query
   logic [COORD_W-1:0] box_x_ff, box_y_ff;
   logic [9:0]         box_id_ff;

   // stage 1: RAM read data
   logic         rd_valid_ff, rd_last_ff;
   nca_cell_type rd_data_ff;

   // stage 2: absolute differences
   logic               dif_valid_ff, dif_last_ff;
   logic [COORD_W-1:0] dx_ff, dy_ff;
   logic [7:0]         dif_row_ff, dif_col_ff;

   // stage 3: squares
   logic                 sq_valid_ff, sq_last_ff;
   logic [2*COORD_W-1:0] dx2_ff, dy2_ff;
   logic [7:0]           sq_row_ff, sq_col_ff;

   // stage 4: running best
   logic              found_ff;
   logic [DIST_W-1:0] best_ff;
   logic [7:0]        best_row_ff, best_col_ff;

   logic        rsp_valid_ff;
   nca_rsp_type rsp_word_ff;

   logic              req_acc;
   logic              issue;
   logic              last_issue;
   logic              finish_go;
   logic              table_full;
   logic [DIST_W-1:0] dist_sum;
   nca_cell_type      wr_cell;

   assign req_acc    = req_valid && !req_stall;
   assign table_full = (count_ff == CNT_W'(TABLE_CELLS));
   assign last_issue = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign dist_sum   = DIST_W'(dx2_ff) + DIST_W'(dy2_ff);

   assign wr_cell.row = req_word.cell_row;
   assign wr_cell.col = req_word.cell_col;
   assign wr_cell.x   = req_word.cell_x;
   assign wr_cell.y   = req_word.cell_y;

   // ---- control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      issue     = 1'b0;
      finish_go = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid && req_word.cmd == CMD_QUERY) begin
               state_in = (count_ff == '0) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            issue = 1'b1;
            if (last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // final compare lands at this edge
            if (sq_valid_ff && sq_last_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               finish_go = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---- table memory
   always_ff @(posedge clock) begin
      if (req_acc && req_word.cmd == CMD_LOAD && !table_full) begin
         mem[count_ff[IDX_W-1:0]] <= wr_cell;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[idx_ff];
   end

   // ---- fill count and scan index
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (req_acc) begin
         if (req_word.cmd == CMD_CLEAR) begin
            count_ff <= '0;
         end else if (req_word.cmd == CMD_LOAD && !table_full) begin
            count_ff <= count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc && req_word.cmd == CMD_QUERY) begin
         idx_ff    <= '0;
         box_x_ff  <= req_word.box_x;
         box_y_ff  <= req_word.box_y;
         box_id_ff <= req_word.box_id;
      end else if (issue) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
   end

   // ---- scan pipe valids
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         dif_valid_ff <= 1'b0;
         sq_valid_ff  <= 1'b0;
      end else begin
         rd_valid_ff  <= issue;
         dif_valid_ff <= rd_valid_ff;
         sq_valid_ff  <= dif_valid_ff;
      end
   end

   // ---- scan pipe data
   always_ff @(posedge clock) begin
      rd_last_ff  <= issue && last_issue;

      dif_last_ff <= rd_last_ff;
      dx_ff       <= (box_x_ff >= rd_data_ff.x) ? box_x_ff - rd_data_ff.x
                                                 : rd_data_ff.x - box_x_ff;
      dy_ff       <= (box_y_ff >= rd_data_ff.y) ? box_y_ff - rd_data_ff.y
                                                 : rd_data_ff.y - box_y_ff;
      dif_row_ff  <= rd_data_ff.row;
      dif_col_ff  <= rd_data_ff.col;

      sq_last_ff  <= dif_last_ff;
      dx2_ff      <= (2*COORD_W)'(dx_ff) * (2*COORD_W)'(dx_ff);
      dy2_ff      <= (2*COORD_W)'(dy_ff) * (2*COORD_W)'(dy_ff);
      sq_row_ff   <= dif_row_ff;
      sq_col_ff   <= dif_col_ff;
   end

   // ---- running minimum, strict compare keeps the earlier cell on a tie
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (req_acc && req_word.cmd == CMD_QUERY) begin
         found_ff <= 1'b0;
      end else if (sq_valid_ff) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc && req_word.cmd == CMD_QUERY) begin
         best_row_ff <= '0;
         best_col_ff <= '0;
      end else if (sq_valid_ff && (!found_ff || dist_sum < best_ff)) begin
         best_ff     <= dist_sum;
         best_row_ff <= sq_row_ff;
         best_col_ff <= sq_col_ff;
      end
   end

   // ---- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish_go) begin
         rsp_word_ff.matched      <= found_ff;
         rsp_word_ff.match_row    <= best_row_ff;
         rsp_word_ff.match_col    <= best_col_ff;
         rsp_word_ff.match_box_id <= box_id_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

[rtl/nca_checker.sv]
// Port-level checks for nearest_cell_assignment_core, bound into that core.
// Depends on nca_pkg.
`timescale 1ns / 1ps

module nca_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input nca_pkg::nca_req_type req_word,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input nca_pkg::nca_rsp_type rsp_word
);
   import nca_pkg::*;

   // out of reset: input open, no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!req_stall && !rsp_valid))
      else $error("block not idle after reset");

   // clear and load words leave the input open
   a_short_cmd: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_word.cmd != CMD_QUERY) |=> !req_stall)
      else $error("input held after clear or load");

   // a query closes the input while the scan runs
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_word.cmd == CMD_QUERY) |=> req_stall)
      else $error("input open during query");

   // a new result only appears at the end of a query
   a_rsp_from_query: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result word without a running query");

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_word)))
      else $error("stalled result word changed");

endmodule

bind nearest_cell_assignment_core nca_checker u_nca_checker (.*);
